// File: design/mbfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbfc_pkg
// Shared constants, opcodes and inter-module types of the bounds culler.
// ----------------------------------------------------------------------------
package mbfc_pkg;

  localparam int NUM_PLANES_DEF = 6;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int Q_W          = 32;
  localparam int OP_W         = 3;
  localparam int SLOT_W       = 3;
  localparam int STRIDE_W     = 7;
  localparam int POS_W        = 6;
  localparam int NUM_AXES     = 3;
  localparam int NUM_COLS     = 4;
  localparam int STRIDE_LIMIT = 64;
  localparam int STRIDE_MIN   = 3;
  localparam int STRIDE_RESET = 8;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_VERTEX = 3'd1;
  localparam logic [OP_W-1:0] OP_PLANE  = 3'd2;
  localparam logic [OP_W-1:0] OP_COLUMN = 3'd3;
  localparam logic [OP_W-1:0] OP_EVAL   = 3'd4;

  typedef logic signed [Q_W-1:0] q_t;

  localparam q_t Q_MAX = 32'sh7fff_ffff;
  localparam q_t Q_MIN = 32'sh8000_0000;

  typedef logic [NUM_AXES-1:0][Q_W-1:0] q3_t;

  typedef struct packed {
    q3_t  lo;
    q3_t  hi;
    logic empty;
  } box_t;

  typedef struct packed {
    logic           clr;
    logic           word;
    logic [Q_W-1:0] data;
  } box_cmd_t;

  typedef struct packed {
    logic              start;
    logic              ld_plane;
    logic              ld_col;
    logic [SLOT_W-1:0] slot;
    logic [Q_W-1:0]    x;
    logic [Q_W-1:0]    y;
    logic [Q_W-1:0]    z;
    logic [Q_W-1:0]    w;
  } eval_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic visible;
    logic box_empty;
  } eval_sts_t;

endpackage
`default_nettype wire

// File: design/mbfc_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbfc_in_if / mbfc_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface mbfc_in_if;
  import mbfc_pkg::*;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [SLOT_W-1:0] slot;
  logic [Q_W-1:0]    coord_x;
  logic [Q_W-1:0]    coord_y;
  logic [Q_W-1:0]    coord_z;
  logic [Q_W-1:0]    coord_w;

  modport source (output valid, output opcode, output slot, output coord_x,
                  output coord_y, output coord_z, output coord_w, input ready);
  modport sink   (input valid, input opcode, input slot, input coord_x,
                  input coord_y, input coord_z, input coord_w, output ready);
endinterface

interface mbfc_out_if;
  logic valid;
  logic ready;
  logic visible;
  logic box_empty;

  modport source (output valid, output visible, output box_empty, input ready);
  modport sink   (input valid, input visible, input box_empty, output ready);
endinterface
`default_nettype wire

// File: design/mbfc_box.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbfc_box
// Vertex word tracker: buffers x/y, widens the local box when z arrives.
// ----------------------------------------------------------------------------
module mbfc_box (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [mbfc_pkg::STRIDE_W-1:0] stride,
  input  mbfc_pkg::box_cmd_t            cmd,
  output mbfc_pkg::box_t                box
);
  import mbfc_pkg::*;

  q_t                lo_r [NUM_AXES];
  q_t                hi_r [NUM_AXES];
  q_t                lo_nxt [NUM_AXES];
  q_t                hi_nxt [NUM_AXES];
  q_t                pend_r [2];
  q_t                pend_nxt [2];
  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic [STRIDE_W-1:0] stride_eff;
  logic [STRIDE_W-1:0] pos_cur;
  logic [STRIDE_W-1:0] pos_inc;
  q_t                pt [NUM_AXES];

  always_comb begin
    stride_eff = (stride > STRIDE_W'(STRIDE_LIMIT)) ? STRIDE_W'(STRIDE_LIMIT) : stride;
    pos_cur    = ({1'b0, pos_r} >= stride_eff) ? '0 : {1'b0, pos_r};
    pos_inc    = pos_cur + STRIDE_W'(1);
    pt[0]      = pend_r[0];
    pt[1]      = pend_r[1];
    pt[2]      = q_t'(cmd.data);
    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    pend_nxt   = pend_r;
    pos_nxt    = pos_r;
    if (cmd.clr) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lo_nxt[k] = Q_MAX;
        hi_nxt[k] = Q_MIN;
      end
      pend_nxt[0] = '0;
      pend_nxt[1] = '0;
      pos_nxt     = '0;
    end else if (cmd.word && stride_eff >= STRIDE_W'(STRIDE_MIN)) begin
      if (pos_cur < STRIDE_W'(2)) begin
        pend_nxt[pos_cur[0]] = q_t'(cmd.data);
      end else if (pos_cur == STRIDE_W'(2)) begin
        for (int k = 0; k < NUM_AXES; k++) begin
          if (pt[k] < lo_r[k]) lo_nxt[k] = pt[k];
          if (pt[k] > hi_r[k]) hi_nxt[k] = pt[k];
        end
      end
      pos_nxt = (pos_inc >= stride_eff) ? '0 : pos_inc[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        lo_r[k] <= Q_MAX;
        hi_r[k] <= Q_MIN;
      end
      pend_r[0] <= '0;
      pend_r[1] <= '0;
      pos_r     <= '0;
    end else begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      pend_r <= pend_nxt;
      pos_r  <= pos_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_AXES; k++) begin
      box.lo[k] = lo_r[k];
      box.hi[k] = hi_r[k];
    end
    box.empty = lo_r[0] > hi_r[0];
  end

endmodule
`default_nettype wire

// File: design/mbfc_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbfc_mul
// Shared signed 32x32 multiplier with product register and floor rescale.
// ----------------------------------------------------------------------------
module mbfc_mul #(
  parameter int FRAC_BITS = mbfc_pkg::FRAC_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    en,
  input  mbfc_pkg::q_t                            a,
  input  mbfc_pkg::q_t                            b,
  output logic signed [2*mbfc_pkg::Q_W-FRAC_BITS-1:0] sh
);
  import mbfc_pkg::*;

  localparam int PROD_W = 2 * Q_W;
  localparam int SH_W   = PROD_W - FRAC_BITS;

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a) * PROD_W'(b);
    end
  end

  // arithmetic shift rounds toward minus infinity
  assign sh = SH_W'(prod_r >>> FRAC_BITS);

endmodule
`default_nettype wire

// File: design/mbfc_eval.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbfc_eval
// Plane/matrix stores and the evaluate sequencer around the shared multiplier.
// ----------------------------------------------------------------------------
module mbfc_eval #(
  parameter int NUM_PLANES = mbfc_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = mbfc_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbfc_pkg::eval_cmd_t  cmd,
  input  mbfc_pkg::box_t       box,
  input  logic                 take,
  output mbfc_pkg::eval_sts_t  sts
);
  import mbfc_pkg::*;

  localparam int SH_W   = 2 * Q_W - FRAC_BITS;
  localparam int ACC_W  = SH_W + 4;
  localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;
  localparam int OUT_W  = (PIDX_W > 2) ? PIDX_W : 2;
  localparam int COL_T  = 3;
  localparam int W_D    = 3;

  typedef logic signed [ACC_W-1:0] acc_t;
  typedef q_t [NUM_COLS-1:0] row_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SETUP, S_MUL, S_ACC, S_FOLD, S_CHECK, S_DONE
  } state_t;

  typedef enum logic [1:0] {P_CW, P_AX, P_PL} phase_t;

  state_t           state_r, state_nxt;
  phase_t           phase_r, phase_nxt;
  logic [OUT_W-1:0] outer_r, outer_nxt;
  logic [1:0]       grp_r, grp_nxt;
  logic [1:0]       idx_r, idx_nxt;
  acc_t             acc_r, acc_nxt;
  acc_t             tot_r, tot_nxt;
  logic             vis_r, vis_nxt;
  logic             empty_r, empty_nxt;
  q_t               half_r [NUM_AXES];
  q_t               half_nxt [NUM_AXES];
  q_t               ctr_r [NUM_AXES];
  q_t               ctr_nxt [NUM_AXES];
  q_t               cw_r [NUM_AXES];
  q_t               cw_nxt [NUM_AXES];
  q_t               ax_r [NUM_AXES][NUM_AXES];
  q_t               ax_nxt [NUM_AXES][NUM_AXES];

  row_t             mrow_r [NUM_AXES];
  row_t             pl_r [NUM_PLANES];

  logic [1:0]       row_sel;
  row_t             mrow_q;
  row_t             prow_q;
  logic [1:0]       ax_sel;
  q_t               op_a, op_b;
  logic             mul_en;
  logic signed [SH_W-1:0] sh;
  acc_t             sh_ext;
  acc_t             acc_base;
  acc_t             acc_abs;
  logic signed [Q_W:0] diff;

  function automatic q_t sat_q(acc_t v);
    if (v > acc_t'(Q_MAX)) begin
      return Q_MAX;
    end else if (v < acc_t'(Q_MIN)) begin
      return Q_MIN;
    end
    return q_t'(v);
  endfunction

  // plane and matrix stores
  always_ff @(posedge clk) begin
    if (cmd.ld_plane && {1'b0, cmd.slot} < (SLOT_W + 1)'(NUM_PLANES)) begin
      pl_r[cmd.slot[PIDX_W-1:0]] <= {q_t'(cmd.w), q_t'(cmd.z), q_t'(cmd.y), q_t'(cmd.x)};
    end
    if (cmd.ld_col && {1'b0, cmd.slot} < (SLOT_W + 1)'(NUM_COLS)) begin
      mrow_r[0][cmd.slot[1:0]] <= q_t'(cmd.x);
      mrow_r[1][cmd.slot[1:0]] <= q_t'(cmd.y);
      mrow_r[2][cmd.slot[1:0]] <= q_t'(cmd.z);
    end
  end

  // operand select
  always_comb begin
    row_sel = (phase_r == P_CW) ? outer_r[1:0] : idx_r;
    mrow_q  = mrow_r[row_sel];
    prow_q  = pl_r[outer_r[PIDX_W-1:0]];
    ax_sel  = grp_r - 2'd1;
    case (phase_r)
      P_CW: begin
        op_a = mrow_q[idx_r];
        op_b = ctr_r[idx_r];
      end
      P_AX: begin
        op_a = mrow_q[outer_r[1:0]];
        op_b = half_r[outer_r[1:0]];
      end
      P_PL: begin
        op_a = prow_q[idx_r];
        op_b = (grp_r == 2'd0) ? cw_r[idx_r] : ax_r[ax_sel][idx_r];
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
    mul_en = (state_r == S_MUL);
  end

  mbfc_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .en  (mul_en),
    .a   (op_a),
    .b   (op_b),
    .sh  (sh)
  );

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    outer_nxt = outer_r;
    grp_nxt   = grp_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    tot_nxt   = tot_r;
    vis_nxt   = vis_r;
    empty_nxt = empty_r;
    half_nxt  = half_r;
    ctr_nxt   = ctr_r;
    cw_nxt    = cw_r;
    ax_nxt    = ax_r;
    sh_ext    = acc_t'(sh);
    acc_abs   = acc_r[ACC_W-1] ? -acc_r : acc_r;
    diff      = '0;
    acc_base  = acc_r;
    case (phase_r)
      P_CW:    acc_base = (idx_r == 2'd0) ? acc_t'(mrow_q[COL_T]) : acc_r;
      P_PL: begin
        if (idx_r == 2'd0) begin
          acc_base = (grp_r == 2'd0) ? acc_t'(prow_q[W_D]) : '0;
        end
      end
      default: acc_base = acc_r;
    endcase

    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          empty_nxt = box.empty;
          vis_nxt   = !box.empty;
          state_nxt = box.empty ? S_DONE : S_SETUP;
        end
      end
      S_SETUP: begin
        for (int k = 0; k < NUM_AXES; k++) begin
          diff        = $signed({box.hi[k][Q_W-1], box.hi[k]})
                      - $signed({box.lo[k][Q_W-1], box.lo[k]});
          half_nxt[k] = q_t'(diff >>> 1);
          ctr_nxt[k]  = q_t'(box.lo[k]) + q_t'(diff >>> 1);
        end
        phase_nxt = P_CW;
        outer_nxt = '0;
        grp_nxt   = '0;
        idx_nxt   = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        acc_nxt   = acc_base + sh_ext;
        state_nxt = S_MUL;
        case (phase_r)
          P_CW, P_AX: begin
            if (phase_r == P_CW) begin
              if (idx_r == 2'd2) cw_nxt[outer_r[1:0]] = sat_q(acc_nxt);
            end else begin
              ax_nxt[outer_r[1:0]][idx_r] = sat_q(sh_ext);
            end
            if (idx_r == 2'd2) begin
              idx_nxt = '0;
              if (outer_r == OUT_W'(2)) begin
                outer_nxt = '0;
                phase_nxt = (phase_r == P_CW) ? P_AX : P_PL;
              end else begin
                outer_nxt = outer_r + OUT_W'(1);
              end
            end else begin
              idx_nxt = idx_r + 2'd1;
            end
          end
          P_PL: begin
            if (idx_r != 2'd2) begin
              idx_nxt = idx_r + 2'd1;
            end else if (grp_r == 2'd0) begin
              tot_nxt = acc_nxt;
              grp_nxt = 2'd1;
              idx_nxt = '0;
            end else begin
              state_nxt = S_FOLD;
            end
          end
          default: state_nxt = S_MUL;
        endcase
      end
      S_FOLD: begin
        tot_nxt = tot_r + acc_abs;
        if (grp_r == 2'd3) begin
          state_nxt = S_CHECK;
        end else begin
          grp_nxt   = grp_r + 2'd1;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_CHECK: begin
        if (tot_r[ACC_W-1]) vis_nxt = 1'b0;
        if (outer_r == OUT_W'(NUM_PLANES - 1)) begin
          state_nxt = S_DONE;
        end else begin
          outer_nxt = outer_r + OUT_W'(1);
          grp_nxt   = '0;
          idx_nxt   = '0;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        if (take) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= P_CW;
      outer_r <= '0;
      grp_r   <= '0;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      outer_r <= outer_nxt;
      grp_r   <= grp_nxt;
      idx_r   <= idx_nxt;
    end
    acc_r   <= acc_nxt;
    tot_r   <= tot_nxt;
    vis_r   <= vis_nxt;
    empty_r <= empty_nxt;
    half_r  <= half_nxt;
    ctr_r   <= ctr_nxt;
    cw_r    <= cw_nxt;
    ax_r    <= ax_nxt;
  end

  always_comb begin
    sts.busy      = (state_r != S_IDLE);
    sts.done      = (state_r == S_DONE);
    sts.visible   = vis_r;
    sts.box_empty = empty_r;
  end

endmodule
`default_nettype wire

// File: design/mesh_bounds_frustum_cull_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mesh_bounds_frustum_cull_core
// Fixed-point mesh bounding box accumulation and frustum visibility test.
// ----------------------------------------------------------------------------
// Clear, vertex word, plane load and column load beats are accepted one per
// cycle, back to back, while no evaluate is in progress. An evaluate beat runs
// all multiplies through one shared 32x32 multiplier, each product taking a
// multiply state and an accumulate state, plus fold and check steps; ready stays
// low meanwhile. An evaluate on an empty box goes straight to done. The result
// beat sits in an output register, so command beats keep flowing while it
// waits to be taken.
module mesh_bounds_frustum_cull_core #(
  parameter int NUM_PLANES = mbfc_pkg::NUM_PLANES_DEF,
  parameter int FRAC_BITS  = mbfc_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  mbfc_in_if.sink                       in_ch,
  mbfc_out_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [mbfc_pkg::STRIDE_W-1:0] cfg_wdata
);
  import mbfc_pkg::*;

  logic [STRIDE_W-1:0] stride_r;
  logic                out_valid_r, out_valid_nxt;
  logic                out_vis_r;
  logic                out_empty_r;
  logic                beat_in;
  logic                take;
  box_cmd_t            box_cmd;
  eval_cmd_t           eval_cmd;
  box_t                box;
  eval_sts_t           sts;

  assign in_ch.ready = !sts.busy;
  assign beat_in     = in_ch.valid && in_ch.ready;
  assign take        = sts.done && (!out_valid_r || out_ch.ready);

  always_comb begin
    box_cmd.clr       = beat_in && (in_ch.opcode == OP_CLEAR);
    box_cmd.word      = beat_in && (in_ch.opcode == OP_VERTEX);
    box_cmd.data      = in_ch.coord_x;
    eval_cmd.start    = beat_in && (in_ch.opcode == OP_EVAL);
    eval_cmd.ld_plane = beat_in && (in_ch.opcode == OP_PLANE);
    eval_cmd.ld_col   = beat_in && (in_ch.opcode == OP_COLUMN);
    eval_cmd.slot     = in_ch.slot;
    eval_cmd.x        = in_ch.coord_x;
    eval_cmd.y        = in_ch.coord_y;
    eval_cmd.z        = in_ch.coord_z;
    eval_cmd.w        = in_ch.coord_w;
    out_valid_nxt     = take ? 1'b1 : (out_valid_r && !out_ch.ready);
  end

  mbfc_box u_box (
    .clk    (clk),
    .rst_n  (rst_n),
    .stride (stride_r),
    .cmd    (box_cmd),
    .box    (box)
  );

  mbfc_eval #(
    .NUM_PLANES (NUM_PLANES),
    .FRAC_BITS  (FRAC_BITS)
  ) u_eval (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (eval_cmd),
    .box   (box),
    .take  (take),
    .sts   (sts)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r    <= STRIDE_W'(STRIDE_RESET);
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) stride_r <= cfg_wdata;
      out_valid_r <= out_valid_nxt;
    end
    if (take) begin
      out_vis_r   <= sts.visible;
      out_empty_r <= sts.box_empty;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.visible   = out_vis_r;
  assign out_ch.box_empty = out_empty_r;

endmodule
`default_nettype wire

// File: test/testbench.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounds culler. Command beats are driven into the
// core and each evaluate verdict is predicted by a fixed-point model of the
// box accumulator and plane test held here. Result beats are compared in order
// against the predicted verdicts. Directed cases come first, then random
// clear/vertex/evaluate streams under varying stride, idling and back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  import mbfc_pkg::*;

  localparam int   PLANE_WORDS   = 4;
  localparam int   SLOT_MAX      = (1 << SLOT_W) - 1;
  localparam int   OP_LAST       = (1 << OP_W) - 1;
  localparam q_t   ONE           = q_t'(1 << FRAC_BITS_DEF);
  localparam int   SETTLE_CYCLES = 300;
  localparam int   LONG_HOLD     = 1500;
  localparam int   CYCLE_LIMIT   = 500000;
  localparam int   REPORT_MAX    = 10;

  typedef struct {
    logic [OP_W-1:0]   opcode;
    logic [SLOT_W-1:0] slot;
    q_t                x;
    q_t                y;
    q_t                z;
    q_t                w;
  } cull_cmd_t;

  typedef struct {
    logic visible;
    logic box_empty;
  } verdict_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [STRIDE_W-1:0] cfg_wdata;

  mbfc_in_if  in_bus ();
  mbfc_out_if out_bus ();

  mesh_bounds_frustum_cull_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // predicted culler state
  logic [STRIDE_W-1:0] stride_cfg;
  longint              box_lo [NUM_AXES];
  longint              box_hi [NUM_AXES];
  int unsigned         vertex_pos;
  longint              xy_held [2];
  longint              plane_q [NUM_PLANES_DEF*PLANE_WORDS];
  longint              column_q [NUM_COLS*NUM_AXES];

  verdict_t verdict_q [$];
  int       mismatches  = 0;
  int       beats_sent  = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 31;
  int       recv_idle_pct = 78;
  logic     hold_token = 1'b0;
  logic     hold_seen  = 1'b0;
  int       hold_left  = 0;

  // ---------------------------------------------------------------- predictor
  function automatic void clear_bounds();
    for (int k = 0; k < NUM_AXES; k++) begin
      box_lo[k] = Q_MAX;
      box_hi[k] = Q_MIN;
    end
    vertex_pos = 0;
    xy_held[0] = 0;
    xy_held[1] = 0;
  endfunction

  function automatic void reset_model();
    stride_cfg = STRIDE_W'(STRIDE_RESET);
    clear_bounds();
    foreach (plane_q[i]) plane_q[i] = 0;
    foreach (column_q[i]) column_q[i] = 0;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return (a * b) >>> FRAC_BITS_DEF;
  endfunction

  function automatic longint q_sat(longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic void take_vertex_word(longint w);
    int unsigned span;
    int unsigned pos;
    longint      pt;
    span = (stride_cfg > STRIDE_LIMIT) ? STRIDE_LIMIT : stride_cfg;
    if (span < STRIDE_MIN) return;
    pos = (vertex_pos >= span) ? 0 : vertex_pos;
    if (pos < NUM_AXES - 1) begin
      xy_held[pos] = w;
    end else if (pos == NUM_AXES - 1) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        pt = (k == NUM_AXES - 1) ? w : xy_held[k];
        if (pt < box_lo[k]) box_lo[k] = pt;
        if (pt > box_hi[k]) box_hi[k] = pt;
      end
    end
    pos++;
    vertex_pos = (pos >= span) ? 0 : pos;
  endfunction

  function automatic logic box_in_view();
    longint half [NUM_AXES];
    longint ctr [NUM_AXES];
    longint world_ctr [NUM_AXES];
    longint axis [NUM_AXES][NUM_AXES];
    longint acc;
    longint plane_dist;
    longint rad;
    for (int c = 0; c < NUM_AXES; c++) begin
      half[c] = (box_hi[c] - box_lo[c]) >>> 1;
      ctr[c]  = box_lo[c] + half[c];
    end
    for (int r = 0; r < NUM_AXES; r++) begin
      acc = column_q[NUM_AXES*NUM_AXES + r];
      for (int c = 0; c < NUM_AXES; c++)
        acc += q_mul(column_q[c*NUM_AXES + r], ctr[c]);
      world_ctr[r] = q_sat(acc);
    end
    for (int c = 0; c < NUM_AXES; c++)
      for (int r = 0; r < NUM_AXES; r++)
        axis[c][r] = q_sat(q_mul(column_q[c*NUM_AXES + r], half[c]));
    for (int p = 0; p < NUM_PLANES_DEF; p++) begin
      plane_dist = plane_q[p*PLANE_WORDS + NUM_AXES];
      rad = 0;
      for (int r = 0; r < NUM_AXES; r++)
        plane_dist += q_mul(plane_q[p*PLANE_WORDS + r], world_ctr[r]);
      for (int c = 0; c < NUM_AXES; c++) begin
        acc = 0;
        for (int r = 0; r < NUM_AXES; r++)
          acc += q_mul(plane_q[p*PLANE_WORDS + r], axis[c][r]);
        rad += (acc < 0) ? -acc : acc;
      end
      if (plane_dist + rad < 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void predict_cull(cull_cmd_t c);
    verdict_t v;
    int       base;
    base = int'(c.slot);
    case (c.opcode)
      OP_CLEAR:  clear_bounds();
      OP_VERTEX: take_vertex_word(c.x);
      OP_PLANE: begin
        if (base < NUM_PLANES_DEF) begin
          plane_q[base*PLANE_WORDS + 0] = c.x;
          plane_q[base*PLANE_WORDS + 1] = c.y;
          plane_q[base*PLANE_WORDS + 2] = c.z;
          plane_q[base*PLANE_WORDS + 3] = c.w;
        end
      end
      OP_COLUMN: begin
        if (base < NUM_COLS) begin
          column_q[base*NUM_AXES + 0] = c.x;
          column_q[base*NUM_AXES + 1] = c.y;
          column_q[base*NUM_AXES + 2] = c.z;
        end
      end
      OP_EVAL: begin
        v.box_empty = (box_lo[0] > box_hi[0]);
        v.visible   = v.box_empty ? 1'b0 : box_in_view();
        verdict_q.push_back(v);
      end
      default: ;
    endcase
  endfunction

  // ---------------------------------------------------------------- checking
  function automatic void report_mismatch(string msg);
    mismatches++;
    if (mismatches <= REPORT_MAX) $display("[%0t] mismatch: %s", $time, msg);
  endfunction

  function automatic void check_verdict(logic vis, logic emp);
    verdict_t want;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("unexpected beat visible=%0b box_empty=%0b", vis, emp));
      return;
    end
    want = verdict_q.pop_front();
    if (vis !== want.visible)
      report_mismatch($sformatf("visible expected %0b got %0b", want.visible, vis));
    if (emp !== want.box_empty)
      report_mismatch($sformatf("box_empty expected %0b got %0b", want.box_empty, emp));
  endfunction

  // result side: random stalls, long hold on request, check every beat
  always @(posedge clk) begin
    if (hold_token != hold_seen) begin
      hold_seen     <= hold_token;
      hold_left     <= LONG_HOLD;
      out_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
    if (rst_n && out_bus.valid && out_bus.ready)
      check_verdict(out_bus.visible, out_bus.box_empty);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic cull_cmd_t pack_cmd(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                         q_t x, q_t y, q_t z, q_t w);
    cull_cmd_t c;
    c.opcode = op;
    c.slot   = slot;
    c.x      = x;
    c.y      = y;
    c.z      = z;
    c.w      = w;
    return c;
  endfunction

  function automatic cull_cmd_t bare_cmd(logic [OP_W-1:0] op);
    return pack_cmd(op, SLOT_W'($urandom_range(0, SLOT_MAX)), q_t'($urandom),
                    q_t'($urandom), q_t'($urandom), q_t'($urandom));
  endfunction

  function automatic q_t rand_near(int span);
    return q_t'(int'($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic q_t coord_sample();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 4) return Q_MIN;
    if (roll < 8) return Q_MAX;
    if (roll < 18) return q_t'($urandom);
    return rand_near(20 << FRAC_BITS_DEF);
  endfunction

  function automatic cull_cmd_t vertex_cmd(q_t word);
    return pack_cmd(OP_VERTEX, SLOT_W'($urandom_range(0, SLOT_MAX)), word,
                    q_t'($urandom), q_t'($urandom), q_t'($urandom));
  endfunction

  function automatic cull_cmd_t plane_sample();
    logic [SLOT_W-1:0] s;
    if ($urandom_range(0, 9) == 0) s = SLOT_W'($urandom_range(NUM_PLANES_DEF, SLOT_MAX));
    else s = SLOT_W'($urandom_range(0, NUM_PLANES_DEF - 1));
    return pack_cmd(OP_PLANE, s, rand_near(ONE), rand_near(ONE), rand_near(ONE),
                    rand_near(40 << FRAC_BITS_DEF));
  endfunction

  function automatic cull_cmd_t column_sample();
    logic [SLOT_W-1:0] s;
    if ($urandom_range(0, 9) == 0) s = SLOT_W'($urandom_range(NUM_COLS, SLOT_MAX));
    else s = SLOT_W'($urandom_range(0, NUM_COLS - 1));
    return pack_cmd(OP_COLUMN, s, rand_near(3 << FRAC_BITS_DEF),
                    rand_near(3 << FRAC_BITS_DEF), rand_near(3 << FRAC_BITS_DEF),
                    q_t'($urandom));
  endfunction

  function automatic cull_cmd_t noise_sample();
    return pack_cmd(OP_W'($urandom_range(0, OP_LAST)), SLOT_W'($urandom_range(0, SLOT_MAX)),
                    q_t'($urandom), q_t'($urandom), q_t'($urandom), q_t'($urandom));
  endfunction

  task automatic push_command(input cull_cmd_t c);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.opcode  <= c.opcode;
    in_bus.slot    <= c.slot;
    in_bus.coord_x <= c.x;
    in_bus.coord_y <= c.y;
    in_bus.coord_z <= c.z;
    in_bus.coord_w <= c.w;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    predict_cull(c);
    beats_sent++;
  endtask

  task automatic wait_drained();
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_stride(input logic [STRIDE_W-1:0] v);
    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we     <= 1'b0;
    stride_cfg = v;
  endtask

  // clear, a few vertices with optional partial tail, evaluate; noise mixed in
  task automatic run_sequence();
    int unsigned span;
    int unsigned nwords;
    span = (stride_cfg > STRIDE_LIMIT) ? STRIDE_LIMIT : stride_cfg;
    if (span < STRIDE_MIN) span = $urandom_range(STRIDE_MIN, 6);
    if ($urandom_range(0, 99) < 85) push_command(bare_cmd(OP_CLEAR));
    if ($urandom_range(0, 99) < 30) push_command(plane_sample());
    if ($urandom_range(0, 99) < 25) push_command(column_sample());
    if (span > 12) begin
      nwords = span + $urandom_range(STRIDE_MIN, 5);
    end else begin
      nwords = span * $urandom_range(1, 4);
      if ($urandom_range(0, 99) < 30) nwords += $urandom_range(1, span - 1);
    end
    for (int i = 0; i < nwords; i++) begin
      if ($urandom_range(0, 99) < 6) push_command(noise_sample());
      push_command(vertex_cmd(coord_sample()));
    end
    push_command(bare_cmd(OP_EVAL));
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_frustum_load();
    q_t nrm [NUM_AXES];
    for (int p = 0; p < NUM_PLANES_DEF; p++) begin
      for (int k = 0; k < NUM_AXES; k++)
        nrm[k] = (k == p / 2) ? ((p % 2) ? -ONE : ONE) : q_t'(0);
      push_command(pack_cmd(OP_PLANE, SLOT_W'(p), nrm[0], nrm[1], nrm[2], 10 * ONE));
    end
    for (int c = 0; c < NUM_COLS; c++)
      push_command(pack_cmd(OP_COLUMN, SLOT_W'(c), (c == 0) ? ONE : q_t'(0),
                            (c == 1) ? ONE : q_t'(0), (c == 2) ? ONE : q_t'(0),
                            q_t'($urandom)));
  endtask

  task automatic test_empty_and_ignored();
    push_command(bare_cmd(OP_EVAL));
    push_command(pack_cmd(OP_PLANE, SLOT_W'(SLOT_MAX), Q_MIN, Q_MIN, Q_MIN, Q_MIN));
    push_command(pack_cmd(OP_COLUMN, SLOT_W'(NUM_COLS), Q_MAX, Q_MAX, Q_MAX, Q_MAX));
    for (int op = int'(OP_EVAL) + 1; op <= OP_LAST; op++)
      push_command(bare_cmd(OP_W'(op)));
  endtask

  task automatic test_extreme_vertex();
    push_command(vertex_cmd(Q_MIN));
    push_command(vertex_cmd(Q_MAX));
    push_command(vertex_cmd(q_t'(0)));
    push_command(bare_cmd(OP_EVAL));
  endtask

  // word position sits past the new stride, so the next word restarts a vertex
  task automatic test_stride_cut();
    write_stride(STRIDE_W'(STRIDE_MIN));
    push_command(vertex_cmd(Q_MAX));
    push_command(vertex_cmd(Q_MIN));
    push_command(vertex_cmd(5 * ONE));
    push_command(bare_cmd(OP_EVAL));
  endtask

  task automatic test_random_stream(input logic [STRIDE_W-1:0] stride, input int target);
    int start;
    write_stride(stride);
    start = beats_sent;
    while (beats_sent - start < target) run_sequence();
  endtask

  task automatic test_backpressure();
    hold_token <= ~hold_token;
    repeat (4) run_sequence();
    in_bus.valid <= 1'b0;
    wait_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.opcode  = '0;
    in_bus.slot    = '0;
    in_bus.coord_x = '0;
    in_bus.coord_y = '0;
    in_bus.coord_z = '0;
    in_bus.coord_w = '0;
    out_bus.ready  = 1'b0;
    reset_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_frustum_load();
    test_empty_and_ignored();
    test_extreme_vertex();
    test_stride_cut();

    test_random_stream(STRIDE_W'(STRIDE_MIN), 70);
    test_random_stream(7'd0, 25);
    test_random_stream(STRIDE_W'(STRIDE_RESET), 60);

    send_idle_pct = 78;
    recv_idle_pct <= 31;
    test_random_stream(7'd127, 60);
    test_random_stream(7'd5, 70);

    send_idle_pct = 0;
    recv_idle_pct <= 0;
    test_backpressure();
    test_random_stream(STRIDE_W'(STRIDE_LIMIT), 60);
    test_random_stream(7'd4, 70);
    test_random_stream(7'd2, 20);

    in_bus.valid <= 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
